FILE: src/wfa_pkg.sv
// ----------------------------------------------------------------------------
// Windowed FIFO average package
// Shared sizes, command and status codes, and the command record passed from
// the front end to the back end.
// ----------------------------------------------------------------------------
package wfa_pkg;

  // Queue window and field widths.
  localparam int WINDOW    = 5;
  localparam int TAG_BITS  = 16;
  localparam int RATE_BITS = 8;

  // Derived widths: entry count, slot index, rate sum and division steps.
  localparam int CNT_BITS  = $clog2(WINDOW + 1);
  localparam int IDX_BITS  = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int WIDE_BITS = CNT_BITS + 1;
  localparam int SUM_BITS  = RATE_BITS + CNT_BITS;
  localparam int STEP_BITS = $clog2(SUM_BITS);

  // Depth of the command queue between front and back.
  localparam int QDEPTH    = 2;
  localparam int QPTR_BITS = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QCNT_BITS = $clog2(QDEPTH + 1);

  // Input mode codes.
  localparam logic MODE_PUSH = 1'b0;

  // Request classes decided by the front end.
  typedef enum logic [1:0] {
    CMD_PUSH      = 2'd0,
    CMD_PUSH_DROP = 2'd1,
    CMD_POP       = 2'd2,
    CMD_POP_EMPTY = 2'd3
  } cmd_e;

  // Result status codes.
  typedef enum logic [1:0] {
    ST_AVERAGE = 2'd0,
    ST_REMOVED = 2'd1,
    ST_EMPTY   = 2'd2
  } status_e;

  // One classified request.
  typedef struct packed {
    cmd_e                 kind;
    logic [TAG_BITS-1:0]  tag;
    logic [RATE_BITS-1:0] rate;
  } cmd_t;

  // Back end sequencer states.
  typedef enum logic [1:0] {
    BK_IDLE  = 2'd0,
    BK_DIV   = 2'd1,
    BK_ROUND = 2'd2
  } back_state_e;

endpackage

FILE: src/wfa_front.sv
// ----------------------------------------------------------------------------
// Windowed FIFO average front end
// Accepts requests and classifies them against a shadow count of the entries
// that the queue will hold once all earlier requests are carried out.
// ----------------------------------------------------------------------------
module wfa_front import wfa_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic                 full_i,
  input  logic                 mode_i,
  input  logic [TAG_BITS-1:0]  item_tag_i,
  input  logic [RATE_BITS-1:0] item_rate_i,
  output logic                 push_o,
  output cmd_t                 cmd_o
);

  logic [CNT_BITS-1:0] count_q, count_d;
  logic                is_full;
  logic                is_empty;

  assign push_o   = start_i && !full_i;
  assign is_full  = (count_q == CNT_BITS'(WINDOW));
  assign is_empty = (count_q == '0);

  // Classify the request and advance the shadow count.
  always_comb begin
    count_d    = count_q;
    cmd_o.tag  = item_tag_i;
    cmd_o.rate = item_rate_i;
    if (mode_i == MODE_PUSH) begin
      if (is_full) begin
        cmd_o.kind = CMD_PUSH_DROP;
      end else begin
        cmd_o.kind = CMD_PUSH;
        count_d    = count_q + CNT_BITS'(1);
      end
    end else begin
      if (is_empty) begin
        cmd_o.kind = CMD_POP_EMPTY;
      end else begin
        cmd_o.kind = CMD_POP;
        count_d    = count_q - CNT_BITS'(1);
      end
    end
  end

  // Shadow count register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (push_o) begin
      count_q <= count_d;
    end
  end

endmodule

FILE: src/wfa_cmd_queue.sv
// ----------------------------------------------------------------------------
// Windowed FIFO average command queue
// A short first-in first-out buffer of classified requests between the front
// end and the back end.
// ----------------------------------------------------------------------------
module wfa_cmd_queue import wfa_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t cmd_i,
  output logic full_o,
  input  logic pop_i,
  output logic valid_o,
  output cmd_t cmd_o
);

  cmd_t                 entry_q [QDEPTH];
  logic [QPTR_BITS-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPTR_BITS-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCNT_BITS-1:0] fill_q, fill_d;

  assign full_o  = (fill_q == QCNT_BITS'(QDEPTH));
  assign valid_o = (fill_q != '0);
  assign cmd_o   = entry_q[rd_ptr_q];

  // Pointer and fill updates.
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    fill_d   = fill_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == QPTR_BITS'(QDEPTH - 1)) ? '0 : wr_ptr_q + QPTR_BITS'(1);
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == QPTR_BITS'(QDEPTH - 1)) ? '0 : rd_ptr_q + QPTR_BITS'(1);
    end
    if (push_i && !pop_i) begin
      fill_d = fill_q + QCNT_BITS'(1);
    end else if (pop_i && !push_i) begin
      fill_d = fill_q - QCNT_BITS'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      fill_q   <= fill_d;
    end
  end

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= cmd_i;
    end
  end

endmodule

FILE: src/wfa_back.sv
// ----------------------------------------------------------------------------
// Windowed FIFO average back end
// Holds the entries, head, count and running sum, carries out each request,
// and divides the sum by the count one quotient bit per cycle for a push.
// ----------------------------------------------------------------------------
module wfa_back import wfa_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 valid_i,
  input  cmd_t                 cmd_i,
  output logic                 pop_o,
  output logic                 done_o,
  output logic [1:0]           status_o,
  output logic [RATE_BITS-1:0] average_o,
  output logic [TAG_BITS-1:0]  removed_tag_o,
  output logic [RATE_BITS-1:0] removed_rate_o
);

  back_state_e state_q, state_d;

  // Entry storage, written only for held entries.
  logic [TAG_BITS-1:0]  tag_q  [WINDOW];
  logic [RATE_BITS-1:0] rate_q [WINDOW];

  logic [IDX_BITS-1:0]  head_q, head_d;
  logic [CNT_BITS-1:0]  count_q, count_d;
  logic [SUM_BITS-1:0]  sum_q, sum_d;

  // Divider registers: dividend shifts out on top, quotient shifts in below.
  logic [SUM_BITS-1:0]  dvd_q, dvd_d;
  logic [CNT_BITS-1:0]  rem_q, rem_d;
  logic [STEP_BITS-1:0] step_q, step_d;

  // Result registers.
  logic                 done_q, done_d;
  status_e              status_q, status_d;
  logic [RATE_BITS-1:0] avg_q, avg_d;
  logic [TAG_BITS-1:0]  rtag_q, rtag_d;
  logic [RATE_BITS-1:0] rrate_q, rrate_d;

  // Store write port.
  logic                 wr_en;
  logic [IDX_BITS-1:0]  wr_idx;

  logic [IDX_BITS-1:0]  head_next;
  logic [WIDE_BITS-1:0] tail_wide;
  logic [IDX_BITS-1:0]  tail_idx;
  logic [RATE_BITS-1:0] head_rate;
  logic [CNT_BITS:0]    rem_shift;
  logic                 rem_ge;
  logic [CNT_BITS:0]    twice_rem;
  logic                 round_up;

  assign done_o         = done_q;
  assign status_o       = status_q;
  assign average_o      = avg_q;
  assign removed_tag_o  = rtag_q;
  assign removed_rate_o = rrate_q;

  // Slot helpers: the next head and the free slot after the held entries.
  assign head_next = (head_q == IDX_BITS'(WINDOW - 1)) ? '0 : head_q + IDX_BITS'(1);
  assign head_rate = rate_q[head_q];
  always_comb begin
    tail_wide = WIDE_BITS'(head_q) + WIDE_BITS'(count_q);
    if (tail_wide >= WIDE_BITS'(WINDOW)) begin
      tail_wide = tail_wide - WIDE_BITS'(WINDOW);
    end
    tail_idx = tail_wide[IDX_BITS-1:0];
  end

  // One restoring division step.
  assign rem_shift = {rem_q, dvd_q[SUM_BITS-1]};
  assign rem_ge    = (rem_shift >= {1'b0, count_q});

  // Round to nearest, ties to the even quotient.
  assign twice_rem = {rem_q, 1'b0};
  assign round_up  = (twice_rem > {1'b0, count_q}) ||
                     ((twice_rem == {1'b0, count_q}) && dvd_q[0]);

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      BK_IDLE: begin
        if (valid_i && (cmd_i.kind == CMD_PUSH || cmd_i.kind == CMD_PUSH_DROP)) begin
          state_d = BK_DIV;
        end
      end
      BK_DIV: begin
        if (step_q == '0) begin
          state_d = BK_ROUND;
        end
      end
      BK_ROUND: state_d = BK_IDLE;
      default:  state_d = BK_IDLE;
    endcase
  end

  // Datapath and result outputs.
  always_comb begin
    pop_o    = 1'b0;
    wr_en    = 1'b0;
    wr_idx   = tail_idx;
    head_d   = head_q;
    count_d  = count_q;
    sum_d    = sum_q;
    dvd_d    = dvd_q;
    rem_d    = rem_q;
    step_d   = step_q;
    done_d   = 1'b0;
    status_d = status_q;
    avg_d    = avg_q;
    rtag_d   = rtag_q;
    rrate_d  = rrate_q;
    unique case (state_q)
      BK_IDLE: begin
        if (valid_i) begin
          pop_o = 1'b1;
          unique case (cmd_i.kind)
            CMD_PUSH: begin
              wr_en   = 1'b1;
              count_d = count_q + CNT_BITS'(1);
              sum_d   = sum_q + SUM_BITS'(cmd_i.rate);
              dvd_d   = sum_q + SUM_BITS'(cmd_i.rate);
              rem_d   = '0;
              step_d  = STEP_BITS'(SUM_BITS - 1);
            end
            CMD_PUSH_DROP: begin
              // The oldest slot is reused for the new entry.
              wr_en  = 1'b1;
              wr_idx = head_q;
              head_d = head_next;
              sum_d  = sum_q - SUM_BITS'(head_rate) + SUM_BITS'(cmd_i.rate);
              dvd_d  = sum_q - SUM_BITS'(head_rate) + SUM_BITS'(cmd_i.rate);
              rem_d  = '0;
              step_d = STEP_BITS'(SUM_BITS - 1);
            end
            CMD_POP: begin
              head_d   = head_next;
              count_d  = count_q - CNT_BITS'(1);
              sum_d    = sum_q - SUM_BITS'(head_rate);
              done_d   = 1'b1;
              status_d = ST_REMOVED;
              avg_d    = '0;
              rtag_d   = tag_q[head_q];
              rrate_d  = head_rate;
            end
            CMD_POP_EMPTY: begin
              done_d   = 1'b1;
              status_d = ST_EMPTY;
              avg_d    = '0;
              rtag_d   = '0;
              rrate_d  = '0;
            end
            default: ;
          endcase
        end
      end
      BK_DIV: begin
        dvd_d  = {dvd_q[SUM_BITS-2:0], rem_ge};
        rem_d  = rem_ge ? CNT_BITS'(rem_shift - {1'b0, count_q}) : rem_shift[CNT_BITS-1:0];
        step_d = step_q - STEP_BITS'(1);
      end
      BK_ROUND: begin
        done_d   = 1'b1;
        status_d = ST_AVERAGE;
        avg_d    = dvd_q[RATE_BITS-1:0] + RATE_BITS'(round_up);
        rtag_d   = '0;
        rrate_d  = '0;
      end
      default: ;
    endcase
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= BK_IDLE;
      head_q  <= '0;
      count_q <= '0;
      sum_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      head_q  <= head_d;
      count_q <= count_d;
      sum_q   <= sum_d;
      done_q  <= done_d;
    end
  end

  // Divider and result payload.
  always_ff @(posedge clk_i) begin
    dvd_q    <= dvd_d;
    rem_q    <= rem_d;
    step_q   <= step_d;
    status_q <= status_d;
    avg_q    <= avg_d;
    rtag_q   <= rtag_d;
    rrate_q  <= rrate_d;
  end

  // Entry storage write.
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      tag_q[wr_idx]  <= cmd_i.tag;
      rate_q[wr_idx] <= cmd_i.rate;
    end
  end

endmodule

FILE: src/windowed_fifo_average_core.sv
// ----------------------------------------------------------------------------
// Windowed FIFO average core
// A queue of up to five tagged rates that reports the rounded mean after each
// push and the removed entry, or an empty status, after each pop.
// ----------------------------------------------------------------------------
// A request is taken when start_i is high and busy_o is low; mode_i selects
// push or pop. Every request gives exactly one result, shown for one cycle
// while done_o is high; the receiver cannot stall and must take it then. A
// push on a full queue drops the oldest entry silently. Pops and pops on an
// empty queue are answered straight from the idle state of the execution
// unit; a push runs a bit-serial divide of the 11-bit rate sum by the entry
// count, one quotient bit per cycle, then a rounding step. A two-entry request
// queue sits in front of the execution unit, so busy_o rises only when two
// requests are waiting behind the one being carried out.
// ----------------------------------------------------------------------------
module windowed_fifo_average_core import wfa_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  output logic                 busy_o,
  input  logic                 mode_i,
  input  logic [TAG_BITS-1:0]  item_tag_i,
  input  logic [RATE_BITS-1:0] item_rate_i,
  output logic                 done_o,
  output logic [1:0]           status_o,
  output logic [RATE_BITS-1:0] average_o,
  output logic [TAG_BITS-1:0]  removed_tag_o,
  output logic [RATE_BITS-1:0] removed_rate_o
);

  logic q_push;
  logic q_full;
  logic q_pop;
  logic q_valid;
  cmd_t front_cmd;
  cmd_t back_cmd;

  assign busy_o = q_full;

  // Request intake and classification.
  wfa_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start_i),
    .full_i      (q_full),
    .mode_i      (mode_i),
    .item_tag_i  (item_tag_i),
    .item_rate_i (item_rate_i),
    .push_o      (q_push),
    .cmd_o       (front_cmd)
  );

  // Request queue between front and back.
  wfa_cmd_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .cmd_i   (front_cmd),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .cmd_o   (back_cmd)
  );

  // Execution unit.
  wfa_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .valid_i        (q_valid),
    .cmd_i          (back_cmd),
    .pop_o          (q_pop),
    .done_o         (done_o),
    .status_o       (status_o),
    .average_o      (average_o),
    .removed_tag_o  (removed_tag_o),
    .removed_rate_o (removed_rate_o)
  );

endmodule
